/* sv/mixed_radix_index_counter_defines.svh */
`ifndef MIXED_RADIX_INDEX_COUNTER_DEFINES_SVH
`define MIXED_RADIX_INDEX_COUNTER_DEFINES_SVH

// same-cycle implication
`define MRI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MRI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/mri_pkg.sv */
package mri_pkg;

   localparam int DIGITS         = 4;
   localparam int DIGIT_BITS     = 8;
   localparam int KEY_BITS       = 32;
   localparam int COUNT_BITS     = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int IDX_BITS       = $clog2(DIGITS);
   localparam int DIV_STEPS      = 4;

   typedef logic [DIGIT_BITS-1:0]             digit_type;
   typedef logic [DIGITS-1:0][DIGIT_BITS-1:0] digit_vec_type;
   typedef logic [IDX_BITS-1:0]               idx_type;
   typedef logic [KEY_BITS-1:0]               key_type;
   typedef logic [COUNT_BITS-1:0]             count_type;
   typedef logic [CSR_INDEX_BITS-1:0]         csr_index_type;

   typedef enum logic [1:0] {
      CMD_LOAD_DIGITS = 2'd0,
      CMD_LOAD_KEY    = 2'd1,
      CMD_STEP_FWD    = 2'd2,
      CMD_STEP_BWD    = 2'd3
   } cmd_type;

   localparam csr_index_type CSR_DIGIT_COUNT = 3'd0;
   localparam csr_index_type CSR_RADIX_0     = 3'd1;
   localparam csr_index_type CSR_RADIX_1     = 3'd2;
   localparam csr_index_type CSR_RADIX_2     = 3'd3;
   localparam csr_index_type CSR_RADIX_3     = 3'd4;

   typedef struct packed {
      logic      start;
      key_type   dividend;
      digit_type divisor;
   } div_req_type;

   typedef struct packed {
      logic      done;
      key_type   quo;
      digit_type rem;
   } div_rsp_type;

   typedef struct packed {
      logic          start;
      digit_vec_type digits;
      digit_vec_type radices;
      idx_type       last_idx;
   } key_req_type;

   typedef struct packed {
      logic    done;
      key_type key;
      logic    ok;
   } key_rsp_type;

endpackage

/* sv/mri_div.sv */
module mri_div import mri_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int ROUNDS   = KEY_BITS / DIV_STEPS;
   localparam int CNT_BITS = $clog2(ROUNDS);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   key_type             quo_ff, quo_in;
   digit_type           rem_ff, rem_in;
   digit_type           div_ff, div_in;
   key_type             quo_step;
   digit_type           rem_step;

   always_comb begin
      logic [DIGIT_BITS:0] part;
      part     = '0;
      quo_step = quo_ff;
      rem_step = rem_ff;
      for (int j = 0; j < DIV_STEPS; j++) begin
         part     = {rem_step, quo_step[KEY_BITS-1]};
         quo_step = {quo_step[KEY_BITS-2:0], 1'b0};
         if (part >= {1'b0, div_ff}) begin
            part        = part - {1'b0, div_ff};
            quo_step[0] = 1'b1;
         end
         rem_step = part[DIGIT_BITS-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         div_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = quo_step;
         rem_in = rem_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(ROUNDS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = quo_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

/* sv/mri_key.sv */
module mri_key import mri_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  key_req_type key_req,
   output key_rsp_type key_rsp
);

   logic      busy_ff, busy_in;
   logic      done_ff, done_in;
   logic      phase_ff, phase_in;
   idx_type   idx_ff, idx_in;
   key_type   size_ff, size_in;
   key_type   acc_ff, acc_in;
   key_type   prod_ff, prod_in;
   logic      zero_ff, zero_in;
   logic      ok_ff, ok_in;
   digit_type cur_digit;
   digit_type cur_radix;
   digit_type digit_m1;

   assign cur_digit = key_req.digits[idx_ff];
   assign cur_radix = key_req.radices[idx_ff];
   assign digit_m1  = cur_digit - 1'b1;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      size_in  = size_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      zero_in  = zero_ff;
      ok_in    = ok_ff;
      if (key_req.start) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         idx_in   = '0;
         size_in  = KEY_BITS'(1);
         acc_in   = '0;
         zero_in  = 1'b0;
         ok_in    = 1'b1;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            prod_in  = {{(KEY_BITS - DIGIT_BITS){1'b0}}, digit_m1} * size_ff;
            zero_in  = zero_ff | (cur_digit == '0);
            ok_in    = ok_ff & (cur_digit != '0) & (cur_digit <= cur_radix);
            phase_in = 1'b1;
         end else begin
            if (!zero_ff) begin
               acc_in  = acc_ff + prod_ff;
               size_in = size_ff * {{(KEY_BITS - DIGIT_BITS){1'b0}}, cur_radix};
            end
            phase_in = 1'b0;
            if (idx_ff == key_req.last_idx) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      size_ff <= size_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      zero_ff <= zero_in;
      ok_ff   <= ok_in;
   end

   assign key_rsp.done = done_ff;
   assign key_rsp.key  = zero_ff ? '0 : acc_ff + 1'b1;
   assign key_rsp.ok   = ok_ff;

endmodule

/* sv/mixed_radix_index_counter.sv */
// Load digits and steps pass the new digits through the key unit before the result; load
// from a nonzero key first runs the iterative divider (four quotient bits a cycle) once per
// active digit, then the key unit, which works through the active digits one by one.
// One request at a time; a new one is taken once the result sits in the output register.
// Reset: digit_count 4, every radix 1, digits all zero, no result pending.
`include "mixed_radix_index_counter_defines.svh"

module mixed_radix_index_counter import mri_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_cmd,
   input  logic [DIGIT_BITS-1:0] req_digit_in_0,
   input  logic [DIGIT_BITS-1:0] req_digit_in_1,
   input  logic [DIGIT_BITS-1:0] req_digit_in_2,
   input  logic [DIGIT_BITS-1:0] req_digit_in_3,
   input  logic [KEY_BITS-1:0]   req_key_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DIGIT_BITS-1:0] rsp_digit_0,
   output logic [DIGIT_BITS-1:0] rsp_digit_1,
   output logic [DIGIT_BITS-1:0] rsp_digit_2,
   output logic [DIGIT_BITS-1:0] rsp_digit_3,
   output logic [KEY_BITS-1:0]   rsp_key_out,
   output logic                  rsp_in_range,
   input  logic                  csr_write_en,
   input  csr_index_type         csr_index,
   input  logic [DIGIT_BITS-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV_START,
      S_DIV_WAIT,
      S_KEY_START,
      S_KEY_WAIT,
      S_OUT
   } state_type;

   state_type     state_ff, state_in;
   count_type     digit_count_ff;
   digit_vec_type radix_ff;
   digit_vec_type digits_ff, digits_in;
   idx_type       idx_ff, idx_in;
   key_type       k_ff, k_in;
   logic          rsp_valid_ff, rsp_valid_in;
   digit_vec_type rsp_digits_ff, rsp_digits_in;
   key_type       rsp_key_ff, rsp_key_in;
   logic          rsp_ok_ff, rsp_ok_in;

   idx_type       last_idx;
   logic [DIGITS-1:0] active;
   digit_vec_type radix_eff;
   digit_vec_type req_digits;
   digit_vec_type base_digits;
   digit_vec_type load_digits;
   digit_vec_type fwd_digits;
   digit_vec_type bwd_digits;
   cmd_type       cmd;
   div_req_type   div_req;
   div_rsp_type   div_rsp;
   key_req_type   key_req;
   key_rsp_type   key_rsp;

   assign req_digits[0] = req_digit_in_0;
   assign req_digits[1] = req_digit_in_1;
   assign req_digits[2] = req_digit_in_2;
   assign req_digits[3] = req_digit_in_3;
   assign cmd           = cmd_type'(req_cmd);

   always_comb begin
      if (digit_count_ff == '0) begin
         last_idx = '0;
      end else if (digit_count_ff > COUNT_BITS'(DIGITS)) begin
         last_idx = IDX_BITS'(DIGITS - 1);
      end else begin
         last_idx = IDX_BITS'(digit_count_ff - 1'b1);
      end
      for (int i = 0; i < DIGITS; i++) begin
         active[i]    = (IDX_BITS'(i) <= last_idx);
         radix_eff[i] = (radix_ff[i] == '0) ? DIGIT_BITS'(1) : radix_ff[i];
      end
   end

   always_comb begin
      logic carry;
      logic hunt;
      carry = 1'b1;
      hunt  = 1'b1;
      for (int i = 0; i < DIGITS; i++) begin
         base_digits[i] = active[i] ? digits_ff[i] : '0;
         load_digits[i] = active[i] ? req_digits[i] : '0;
      end
      fwd_digits = base_digits;
      bwd_digits = base_digits;
      for (int i = 0; i < DIGITS; i++) begin
         if (active[i] && carry) begin
            if ({1'b0, base_digits[i]} + 1'b1 <= {1'b0, radix_eff[i]}) begin
               fwd_digits[i] = base_digits[i] + 1'b1;
               carry         = 1'b0;
            end else begin
               fwd_digits[i] = DIGIT_BITS'(1);
            end
         end
         if (active[i] && hunt) begin
            if (base_digits[i] == DIGIT_BITS'(1)) begin
               bwd_digits[i] = radix_eff[i];
            end else begin
               bwd_digits[i] = base_digits[i] - 1'b1;
               hunt          = 1'b0;
            end
         end
      end
      if (carry) begin
         fwd_digits = '0;
      end
      if (hunt) begin
         bwd_digits = '0;
      end
   end

   assign div_req.start    = (state_ff == S_DIV_START);
   assign div_req.dividend = k_ff;
   assign div_req.divisor  = radix_eff[idx_ff];

   assign key_req.start    = (state_ff == S_KEY_START);
   assign key_req.digits   = digits_ff;
   assign key_req.radices  = radix_eff;
   assign key_req.last_idx = last_idx;

   mri_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   mri_key u_key (
      .clock   (clock),
      .reset   (reset),
      .key_req (key_req),
      .key_rsp (key_rsp)
   );

   always_comb begin
      state_in      = state_ff;
      digits_in     = digits_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_digits_in = rsp_digits_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_ok_in     = rsp_ok_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_KEY_START;
               unique case (cmd)
                  CMD_LOAD_DIGITS: digits_in = load_digits;
                  CMD_LOAD_KEY: begin
                     if (req_key_in == '0) begin
                        digits_in = '0;
                     end else begin
                        digits_in = base_digits;
                        k_in      = req_key_in - 1'b1;
                        idx_in    = '0;
                        state_in  = S_DIV_START;
                     end
                  end
                  CMD_STEP_FWD: digits_in = fwd_digits;
                  CMD_STEP_BWD: digits_in = bwd_digits;
                  default:      digits_in = base_digits;
               endcase
            end
         end
         S_DIV_START: state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               digits_in[idx_ff] = div_rsp.rem + 1'b1;
               k_in              = div_rsp.quo;
               if (idx_ff == last_idx) begin
                  state_in = S_KEY_START;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_DIV_START;
               end
            end
         end
         S_KEY_START: state_in = S_KEY_WAIT;
         S_KEY_WAIT: begin
            if (key_rsp.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_digits_in = digits_ff;
               rsp_key_in    = key_rsp.key;
               rsp_ok_in     = key_rsp.ok;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         digits_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         digits_ff     <= digits_in;
         idx_ff        <= idx_in;
         k_ff          <= k_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_digits_ff <= rsp_digits_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_ok_ff     <= rsp_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= COUNT_BITS'(DIGITS);
         for (int i = 0; i < DIGITS; i++) begin
            radix_ff[i] <= DIGIT_BITS'(1);
         end
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_DIGIT_COUNT: digit_count_ff <= csr_wdata[COUNT_BITS-1:0];
            CSR_RADIX_0:     radix_ff[0]    <= csr_wdata;
            CSR_RADIX_1:     radix_ff[1]    <= csr_wdata;
            CSR_RADIX_2:     radix_ff[2]    <= csr_wdata;
            CSR_RADIX_3:     radix_ff[3]    <= csr_wdata;
            default:         digit_count_ff <= digit_count_ff;
         endcase
      end
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_digit_0  = rsp_digits_ff[0];
   assign rsp_digit_1  = rsp_digits_ff[1];
   assign rsp_digit_2  = rsp_digits_ff[2];
   assign rsp_digit_3  = rsp_digits_ff[3];
   assign rsp_key_out  = rsp_key_ff;
   assign rsp_in_range = rsp_ok_ff;

   `MRI_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "request accepted but block still ready")
   `MRI_ASSERT_SAME(a_in_range_key, clock, reset, rsp_valid && rsp_in_range, rsp_key_out != '0, "in-range result with zero key")
   `MRI_ASSERT_SAME(a_key_digit0, clock, reset, rsp_valid && (rsp_key_out != '0), rsp_digit_0 != '0, "nonzero key with zero low digit")

endmodule

/* tb/sv/mixed_radix_index_counter_tb.sv */
`timescale 1ns / 1ps

module mixed_radix_index_counter_tb;
   import mri_pkg::*;

   localparam int MAX_IDLE       = 11;
   localparam int DRAIN_CYCLES   = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;
   localparam int RANDOM_PHASES  = 23;
   localparam int PHASE_ITEMS    = 80;

   typedef struct packed {
      digit_vec_type digits;
      key_type       key;
      logic          in_range;
   } counter_result_type;

   logic          clock          = 1'b0;
   logic          reset          = 1'b1;
   logic          req_valid      = 1'b0;
   logic          req_ready;
   logic [1:0]    req_cmd        = CMD_LOAD_DIGITS;
   digit_type     req_digit_in_0 = '0;
   digit_type     req_digit_in_1 = '0;
   digit_type     req_digit_in_2 = '0;
   digit_type     req_digit_in_3 = '0;
   key_type       req_key_in     = '0;
   logic          rsp_valid;
   logic          rsp_ready      = 1'b0;
   digit_type     rsp_digit_0;
   digit_type     rsp_digit_1;
   digit_type     rsp_digit_2;
   digit_type     rsp_digit_3;
   key_type       rsp_key_out;
   logic          rsp_in_range;
   logic          csr_write_en   = 1'b0;
   csr_index_type csr_index      = CSR_DIGIT_COUNT;
   digit_type     csr_wdata      = '0;

   count_type     model_count           = 3'd4;
   digit_type     model_radix [DIGITS]  = '{default: 8'd1};
   digit_vec_type model_digits          = '0;

   counter_result_type expected_results [$];
   int mismatch_count = 0;
   int rsp_hold       = 0;
   int idle_cycles    = 0;
   bit no_idle        = 1'b0;

   mixed_radix_index_counter u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_digit_in_0 (req_digit_in_0),
      .req_digit_in_1 (req_digit_in_1),
      .req_digit_in_2 (req_digit_in_2),
      .req_digit_in_3 (req_digit_in_3),
      .req_key_in     (req_key_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_0    (rsp_digit_0),
      .rsp_digit_1    (rsp_digit_1),
      .rsp_digit_2    (rsp_digit_2),
      .rsp_digit_3    (rsp_digit_3),
      .rsp_key_out    (rsp_key_out),
      .rsp_in_range   (rsp_in_range),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, MAX_IDLE);
   endfunction

   function automatic int active_digits();
      if (model_count == 0) return 1;
      if (model_count > DIGITS) return DIGITS;
      return model_count;
   endfunction

   function automatic int unsigned eff_radix(int i);
      return (model_radix[i] == 0) ? 1 : model_radix[i];
   endfunction

   function automatic digit_vec_type pack_digits(digit_type d0, digit_type d1,
                                                 digit_type d2, digit_type d3);
      return {d3, d2, d1, d0};
   endfunction

   function automatic digit_vec_type random_digits();
      return {digit_type'($urandom_range(0, 255)), digit_type'($urandom_range(0, 255)),
              digit_type'($urandom_range(0, 255)), digit_type'($urandom_range(0, 255))};
   endfunction

   function automatic digit_vec_type legal_digits();
      digit_vec_type d;
      int i;
      for (i = 0; i < DIGITS; i++) begin
         if (i < active_digits()) d[i] = digit_type'($urandom_range(1, eff_radix(i)));
         else d[i] = digit_type'($urandom_range(0, 255));
      end
      return d;
   endfunction

   function automatic key_type legal_key();
      longint span;
      int i;
      span = 1;
      for (i = 0; i < active_digits(); i++) span = span * eff_radix(i);
      if ($urandom_range(0, 9) == 0) return $urandom();
      return $urandom_range(0, key_type'(span));
   endfunction

   function automatic digit_type random_radix();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return digit_type'($urandom_range(1, 5));
      if (pick < 80) return digit_type'($urandom_range(0, 255));
      case ($urandom_range(0, 2))
         0: return 8'd0;
         1: return 8'd1;
         default: return 8'd255;
      endcase
   endfunction

   function automatic counter_result_type advance_counter(cmd_type cmd, digit_vec_type din,
                                                          key_type key);
      counter_result_type res;
      int n, i;
      int unsigned v;
      key_type k, sum, size;
      logic carry, zero;
      n = active_digits();
      for (i = n; i < DIGITS; i++) model_digits[i] = '0;
      case (cmd)
         CMD_LOAD_DIGITS: begin
            for (i = 0; i < n; i++) model_digits[i] = din[i];
         end
         CMD_LOAD_KEY: begin
            if (key == 0) begin
               model_digits = '0;
            end else begin
               k = key - 1;
               for (i = 0; i < n; i++) begin
                  model_digits[i] = digit_type'(k % eff_radix(i) + 1);
                  k = k / eff_radix(i);
               end
            end
         end
         CMD_STEP_FWD: begin
            carry = 1'b1;
            for (i = 0; i < n && carry; i++) begin
               v = model_digits[i] + 1;
               if (v <= eff_radix(i)) begin
                  model_digits[i] = digit_type'(v);
                  carry = 1'b0;
               end else begin
                  model_digits[i] = 8'd1;
               end
            end
            if (carry) model_digits = '0;
         end
         default: begin
            i = 0;
            while (i < n && model_digits[i] == 8'd1) begin
               model_digits[i] = digit_type'(eff_radix(i));
               i++;
            end
            if (i >= n) model_digits = '0;
            else model_digits[i] = model_digits[i] - 8'd1;
         end
      endcase
      sum = '0;
      size = 32'd1;
      zero = 1'b0;
      res.in_range = 1'b1;
      for (i = 0; i < n; i++) begin
         if (model_digits[i] == 0) zero = 1'b1;
         if (model_digits[i] == 0 || model_digits[i] > eff_radix(i)) res.in_range = 1'b0;
         if (!zero) begin
            sum = sum + (key_type'(model_digits[i]) - 1) * size;
            size = size * eff_radix(i);
         end
      end
      res.key = zero ? '0 : sum + 1;
      res.digits = model_digits;
      return res;
   endfunction

   function automatic void check_field(string name, key_type want, key_type got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch %s: expected %0h, got %0h", name, want, got);
      end
   endfunction

   task automatic send_request(cmd_type cmd, digit_vec_type din, key_type key);
      int gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_digit_in_0 <= din[0];
      req_digit_in_1 <= din[1];
      req_digit_in_2 <= din[2];
      req_digit_in_3 <= din[3];
      req_key_in     <= key;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(advance_counter(cmd, din, key));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, digit_type data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      if (idx == CSR_DIGIT_COUNT) model_count = data[COUNT_BITS-1:0];
      else if (idx >= CSR_RADIX_0 && idx <= CSR_RADIX_3) model_radix[idx - CSR_RADIX_0] = data;
      @(posedge clock);
   endtask

   task automatic configure(digit_type count_word, digit_type r0, digit_type r1,
                            digit_type r2, digit_type r3);
      wait_idle();
      write_csr(CSR_DIGIT_COUNT, count_word);
      write_csr(CSR_RADIX_0, r0);
      write_csr(CSR_RADIX_1, r1);
      write_csr(CSR_RADIX_2, r2);
      write_csr(CSR_RADIX_3, r3);
      csr_write_en <= 1'b0;
   endtask

   task automatic test_reset_state();
      send_request(CMD_STEP_FWD, random_digits(), $urandom());
      send_request(CMD_STEP_BWD, random_digits(), $urandom());
   endtask

   task automatic test_load_digits();
      configure(8'd4, 8'd255, 8'd1, 8'd7, 8'd0);
      send_request(CMD_LOAD_DIGITS, '0, 32'hFFFF_FFFF);
      send_request(CMD_LOAD_DIGITS, '1, '0);
      send_request(CMD_LOAD_DIGITS, pack_digits(8'd255, 8'd1, 8'd7, 8'd1), $urandom());
      send_request(CMD_LOAD_DIGITS, pack_digits(8'd3, 8'd1, 8'd8, 8'd2), $urandom());
   endtask

   task automatic test_load_key();
      configure(8'd4, 8'd3, 8'd4, 8'd5, 8'd6);
      send_request(CMD_LOAD_KEY, random_digits(), 32'd0);
      send_request(CMD_LOAD_KEY, random_digits(), 32'd1);
      send_request(CMD_LOAD_KEY, random_digits(), 32'd360);
      send_request(CMD_LOAD_KEY, random_digits(), 32'd361);
      send_request(CMD_LOAD_KEY, random_digits(), 32'hFFFF_FFFF);
      configure(8'd4, 8'd255, 8'd255, 8'd255, 8'd255);
      send_request(CMD_LOAD_KEY, random_digits(), 32'hFFFF_FFFF);
      send_request(CMD_LOAD_KEY, random_digits(), 32'd4228250625);
   endtask

   task automatic test_step_forward();
      configure(8'd3, 8'd2, 8'd3, 8'd2, 8'd9);
      send_request(CMD_LOAD_DIGITS, pack_digits(8'd2, 8'd3, 8'd1, 8'd255), $urandom());
      send_request(CMD_STEP_FWD, random_digits(), $urandom());
      send_request(CMD_STEP_FWD, random_digits(), $urandom());
      send_request(CMD_LOAD_DIGITS, pack_digits(8'd2, 8'd3, 8'd2, 8'd9), $urandom());
      send_request(CMD_STEP_FWD, random_digits(), $urandom());
      send_request(CMD_STEP_FWD, random_digits(), $urandom());
   endtask

   task automatic test_step_backward();
      send_request(CMD_LOAD_DIGITS, pack_digits(8'd1, 8'd1, 8'd1, 8'd1), $urandom());
      send_request(CMD_STEP_BWD, random_digits(), $urandom());
      send_request(CMD_LOAD_DIGITS, pack_digits(8'd1, 8'd0, 8'd5, 8'd0), $urandom());
      send_request(CMD_STEP_BWD, random_digits(), $urandom());
      send_request(CMD_STEP_BWD, random_digits(), $urandom());
   endtask

   task automatic test_digit_count();
      int j;
      configure(8'h00, 8'd3, 8'd4, 8'd5, 8'd6);
      send_request(CMD_LOAD_DIGITS, pack_digits(8'd5, 8'd6, 8'd7, 8'd8), $urandom());
      configure(8'hFD, 8'd3, 8'd4, 8'd5, 8'd6);
      send_request(CMD_LOAD_KEY, random_digits(), 32'd100);
      wait_idle();
      for (j = CSR_RADIX_3 + 1; j < (1 << CSR_INDEX_BITS); j++)
         write_csr(csr_index_type'(j), digit_type'($urandom_range(0, 255)));
      csr_write_en <= 1'b0;
      send_request(CMD_LOAD_KEY, random_digits(), 32'hFFFF_FFFF);
   endtask

   task automatic test_random_sequences();
      int phase, sent, run;
      int unsigned c;
      cmd_type dir;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         no_idle = (phase % 6 == 5);
         case (phase)
            0: configure(8'd4, 8'd255, 8'd255, 8'd255, 8'd255);
            1: configure(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
            2: configure(8'd4, 8'd0, 8'd0, 8'd0, 8'd0);
            3: configure(8'd4, 8'd2, 8'd2, 8'd2, 8'd2);
            default: begin
               c = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 8) % 8;
               configure(digit_type'(($urandom_range(0, 31) << COUNT_BITS) | c),
                         random_radix(), random_radix(), random_radix(), random_radix());
            end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 15) begin
               send_request(cmd_type'($urandom_range(0, 3)), random_digits(), $urandom());
               sent++;
            end else begin
               if ($urandom_range(0, 1)) send_request(CMD_LOAD_KEY, random_digits(), legal_key());
               else send_request(CMD_LOAD_DIGITS, legal_digits(), $urandom());
               run = $urandom_range(1, 20);
               dir = $urandom_range(0, 1) ? CMD_STEP_FWD : CMD_STEP_BWD;
               repeat (run) begin
                  if ($urandom_range(0, 9) < 8) send_request(dir, random_digits(), $urandom());
                  else send_request(dir == CMD_STEP_FWD ? CMD_STEP_BWD : CMD_STEP_FWD,
                                    random_digits(), $urandom());
               end
               sent += run + 1;
            end
         end
      end
      no_idle = 1'b0;
   endtask

   always @(posedge clock) begin : check_results
      counter_result_type want;
      int hold;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result: digits %h %h %h %h key %h in_range %b",
                        rsp_digit_3, rsp_digit_2, rsp_digit_1, rsp_digit_0,
                        rsp_key_out, rsp_in_range);
         end else begin
            want = expected_results.pop_front();
            check_field("digit_0", want.digits[0], rsp_digit_0);
            check_field("digit_1", want.digits[1], rsp_digit_1);
            check_field("digit_2", want.digits[2], rsp_digit_2);
            check_field("digit_3", want.digits[3], rsp_digit_3);
            check_field("key_out", want.key, rsp_key_out);
            check_field("in_range", want.in_range, rsp_in_range);
         end
         hold = draw_gap();
         rsp_hold  <= hold;
         rsp_ready <= (hold == 0);
      end else if (rsp_hold != 0) begin
         if (rsp_valid) begin
            rsp_hold  <= rsp_hold - 1;
            rsp_ready <= (rsp_hold == 1);
         end
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_load_digits();
      test_load_key();
      test_step_forward();
      test_step_backward();
      test_digit_count();
      test_random_sequences();
      wait_idle();
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
